// ----- rtl/lrr_pkg.sv -----
// ----------------------------------------------------------------------------
// lrr_pkg: shared constants and types of the Lanczos row resampler
// Widths of the pixel, weight and accumulator paths, the tuser flag layout
// and the control struct that steers the per-channel lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package lrr_pkg;

   localparam int HALF_TAPS        = 3;
   localparam int CHANNELS         = 3;
   localparam int MAX_LINE         = 4096;
   localparam int WEIGHT_FRAC_BITS = 14;

   localparam int TAPS     = 2 * HALF_TAPS;
   localparam int CHAN_W   = 8;
   localparam int PIX_W    = CHANNELS * CHAN_W;
   localparam int WEIGHT_W = 16;
   localparam int LEN_W    = 13;
   localparam int CNT_W    = $clog2(MAX_LINE + 1);

   // A signed 16-bit weight times an unsigned byte fits 24 signed bits.
   localparam int PROD_W = WEIGHT_W + CHAN_W;
   localparam int ACC_W  = PROD_W + $clog2(TAPS);

   localparam int REQ_DATA_W = ((PIX_W + TAPS * WEIGHT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((PIX_W + 7) / 8) * 8;
   localparam int USER_W     = 3;

   // Bit positions of the flags in req_tuser.
   localparam int USER_PUSH  = 0;
   localparam int USER_EMIT  = 1;
   localparam int USER_START = 2;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1920);

   typedef logic [TAPS-1:0][CHAN_W-1:0]   lane_samples_type;
   typedef logic [TAPS-1:0][WEIGHT_W-1:0] lane_weights_type;

   typedef struct packed {
      logic load_prod;   // capture products of a new emitting transfer
      logic load_sum;    // move products into the clamped result register
   } lrr_lane_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/lrr_lane.sv -----
// ----------------------------------------------------------------------------
// lrr_lane: one channel of the six-tap filter
// Multiplies the channel's window bytes by the weights, then sums, clamps
// between the two centre samples and floors to a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lrr_lane
   import lrr_pkg::*;
(
   input  wire  logic             clock,
   input  wire  lrr_lane_ctl_type ctl,
   input  wire  lane_samples_type samples,
   input  wire  lane_weights_type weights,
   output logic [CHAN_W-1:0]      result
);

   logic signed [PROD_W-1:0]          prod_ff [TAPS];
   logic signed [PROD_W-1:0]          prod_in [TAPS];
   logic signed [WEIGHT_W+CHAN_W:0]   full_prod [TAPS];
   logic [CHAN_W-1:0]                 lo_ff, lo_in, hi_ff, hi_in;
   logic [CHAN_W-1:0]                 result_ff, result_in;
   logic signed [ACC_W-1:0]           acc, lo_s, hi_s, kept;

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         full_prod[i] = $signed(weights[i]) * $signed({1'b0, samples[i]});
         prod_in[i]   = full_prod[i][PROD_W-1:0];
      end
      if (samples[HALF_TAPS-1] < samples[HALF_TAPS]) begin
         lo_in = samples[HALF_TAPS-1];
         hi_in = samples[HALF_TAPS];
      end else begin
         lo_in = samples[HALF_TAPS];
         hi_in = samples[HALF_TAPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         prod_ff <= prod_in;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
      end
   end

   // Full-precision sum, then the anti-ringing clamp.
   always_comb begin
      acc = '0;
      for (int i = 0; i < TAPS; i++) begin
         acc = acc + ACC_W'(prod_ff[i]);
      end
      lo_s = $signed({{(ACC_W-CHAN_W-WEIGHT_FRAC_BITS){1'b0}}, lo_ff,
                      {WEIGHT_FRAC_BITS{1'b0}}});
      hi_s = $signed({{(ACC_W-CHAN_W-WEIGHT_FRAC_BITS){1'b0}}, hi_ff,
                      {WEIGHT_FRAC_BITS{1'b0}}});
      if (acc < lo_s) begin
         kept = lo_s;
      end else if (acc > hi_s) begin
         kept = hi_s;
      end else begin
         kept = acc;
      end
      result_in = kept[WEIGHT_FRAC_BITS +: CHAN_W];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_sum) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ----- rtl/lrr_merge.sv -----
// ----------------------------------------------------------------------------
// lrr_merge: joins the lane bytes into one pixel
// Packs the channel results, channel 0 lowest, into the output register
// that drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lrr_merge
   import lrr_pkg::*;
(
   input  wire  logic                              clock,
   input  wire  logic                              reset,
   input  wire  logic                              lanes_valid,
   input  wire  logic [CHANNELS-1:0][CHAN_W-1:0]   lanes_result,
   output logic                                    lanes_take,
   output logic                                    rsp_tvalid,
   input  wire  logic                              rsp_tready,
   output logic [RSP_DATA_W-1:0]                   rsp_tdata
);

   logic                  valid_ff, valid_in;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic                  room;

   assign room       = !valid_ff || rsp_tready;
   assign lanes_take = lanes_valid && room;

   always_comb begin
      data_in = RSP_DATA_W'(lanes_result);
      if (lanes_take) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lanes_take) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/lanczos_row_resampler.sv -----
// ----------------------------------------------------------------------------
// lanczos_row_resampler: six-tap Lanczos row filter with anti-ringing clamp
// Keeps a window of six packed pixels, filters it per channel in parallel
// lanes and shifts new samples in, holding the edge past the line length.
// ----------------------------------------------------------------------------
//
//   Port group   Direction  Width        Carries
//   req_*        in         120 + 3      pixel, six weights, flags
//   rsp_*        out        24           filtered pixel
//   csr_*        in         13           line length
//
// A sustained rate of one transfer per clock is reached while the result
// channel does not stall, set by the window update, which completes in the
// cycle of the transfer. A filtered pixel passes, in order, the lane product
// register, the clamped sum register and the output register.
// Reset (synchronous, active high) clears the window, the pushed count and the
// pipeline valids and sets the line length to 1920.
// A stall on rsp_tready backs up only as far as the first empty stage, so
// transfers keep being taken while a result waits, until every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module lanczos_row_resampler
   import lrr_pkg::*;
(
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   // Input channel.
   input  wire  logic                  req_tvalid,
   output logic                        req_tready,
   // tdata: pixel_in[23:0], weight_0 .. weight_5 (16 bits each) from bit 24 up
   input  wire  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: push_req[0], emit[1], start_line[2]
   input  wire  logic [USER_W-1:0]     req_tuser,
   // Result channel.
   output logic                        rsp_tvalid,
   input  wire  logic                  rsp_tready,
   // tdata: pixel_out[23:0]
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   // Line length register.
   input  wire  logic                  csr_wr_en,
   input  wire  logic [LEN_W-1:0]      csr_wr_data
);

   logic [TAPS-1:0][PIX_W-1:0]    win_ff, win_in, win_clr;
   logic [CNT_W-1:0]              count_ff, count_in, count_clr, limit;
   logic [LEN_W-1:0]              line_len_ff;
   logic                          prod_valid_ff, prod_valid_in;
   logic                          sum_valid_ff, sum_valid_in;
   logic                          req_take, do_push, do_emit, do_start;
   logic                          sum_room, sum_take;
   logic [PIX_W-1:0]              pixel_in, next_sample;
   lane_weights_type              weights;
   lrr_lane_ctl_type              lane_ctl;
   logic [CHANNELS-1:0][CHAN_W-1:0] lane_result;

   // Unpack the transfer.
   assign pixel_in = req_tdata[PIX_W-1:0];
   assign weights  = req_tdata[PIX_W +: TAPS*WEIGHT_W];
   assign do_push  = req_tuser[USER_PUSH];
   assign do_emit  = req_tuser[USER_EMIT];
   assign do_start = req_tuser[USER_START];

   // The product stage may take a new item when it is empty or moving on.
   assign sum_room   = !sum_valid_ff || sum_take;
   assign req_tready = !prod_valid_ff || sum_room;
   assign req_take   = req_tvalid && req_tready;

   // Window and count after an optional line start; the lanes filter this
   // view, and the push then shifts it.
   always_comb begin
      if (do_start) begin
         win_clr   = '0;
         count_clr = '0;
      end else begin
         win_clr   = win_ff;
         count_clr = count_ff;
      end

      if (32'(line_len_ff) > MAX_LINE) begin
         limit = CNT_W'(MAX_LINE);
      end else begin
         limit = CNT_W'(line_len_ff);
      end

      // Edge hold: once the line is used up, repeat the newest sample.
      if (count_clr >= limit) begin
         next_sample = win_clr[TAPS-1];
      end else begin
         next_sample = pixel_in;
      end

      win_in   = win_clr;
      count_in = count_clr;
      if (do_push) begin
         for (int i = 0; i < TAPS-1; i++) begin
            win_in[i] = win_clr[i+1];
         end
         win_in[TAPS-1] = next_sample;
         if (32'(count_clr) < MAX_LINE) begin
            count_in = count_clr + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff      <= '0;
         count_ff    <= '0;
         line_len_ff <= LEN_RESET;
      end else begin
         if (req_take) begin
            win_ff   <= win_in;
            count_ff <= count_in;
         end
         if (csr_wr_en) begin
            line_len_ff <= csr_wr_data;
         end
      end
   end

   // Pipeline valids: products, then clamped sums, then the output register.
   assign lane_ctl.load_prod = req_take && do_emit;
   assign lane_ctl.load_sum  = prod_valid_ff && sum_room;

   always_comb begin
      if (lane_ctl.load_prod) begin
         prod_valid_in = 1'b1;
      end else if (lane_ctl.load_sum) begin
         prod_valid_in = 1'b0;
      end else begin
         prod_valid_in = prod_valid_ff;
      end

      if (lane_ctl.load_sum) begin
         sum_valid_in = 1'b1;
      end else if (sum_take) begin
         sum_valid_in = 1'b0;
      end else begin
         sum_valid_in = sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         sum_valid_ff  <= sum_valid_in;
      end
   end

   // One lane per color channel, each seeing its byte of every window entry.
   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      lane_samples_type lane_samples;

      always_comb begin
         for (int i = 0; i < TAPS; i++) begin
            lane_samples[i] = win_clr[i][c*CHAN_W +: CHAN_W];
         end
      end

      lrr_lane u_lane (
         .clock   (clock),
         .ctl     (lane_ctl),
         .samples (lane_samples),
         .weights (weights),
         .result  (lane_result[c])
      );
   end

   lrr_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .lanes_valid  (sum_valid_ff),
      .lanes_result (lane_result),
      .lanes_take   (sum_take),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

   // The pushed count never passes the line maximum.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_LINE)
      else $error("pushed count above maximum");

   // A line start without a push leaves the count at zero.
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      req_take && do_start && !do_push |=> count_ff == '0)
      else $error("line start did not clear count");

   // A push below the maximum, without a line start, raises the count by one.
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      req_take && !do_start && do_push && (32'(count_ff) < MAX_LINE)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not advance count");

   // An emitting transfer always lands in the product stage.
   a_emit_enters: assert property (@(posedge clock) disable iff (reset)
      req_take && do_emit |=> prod_valid_ff)
      else $error("emitting transfer lost");

   // With every stage full and the output stalled, nothing is taken.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff && sum_valid_ff && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("transfer taken into a full pipeline");

endmodule

`default_nettype wire
